// ===== rtl/fimc_pkg.sv =====
// shared types, codes and helpers of the feeder index motor controller
package fimc_pkg;

  localparam int unsigned PWM_W    = 12;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned BRAKE_W  = 8;
  localparam int unsigned DRIVE_W  = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [PWM_W-1:0]   PWM_FULL   = 12'd2048;
  localparam logic [TIMER_W-1:0] INIT_TIMER = 16'd200;

  // button event codes
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_SHORT = 2'd1;
  localparam logic [1:0] BTN_LONG  = 2'd2;
  localparam logic [1:0] BTN_HOLD  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_TMO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_TMO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DRIVE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JOG_DRIVE   = 3'd6;

  // reported mode codes
  localparam logic [2:0] FMC_INIT       = 3'd0;
  localparam logic [2:0] FMC_IDLE       = 3'd1;
  localparam logic [2:0] FMC_FWD_LEAVE  = 3'd2;
  localparam logic [2:0] FMC_BACK_LEAVE = 3'd3;
  localparam logic [2:0] FMC_FWD_REACH  = 3'd4;
  localparam logic [2:0] FMC_BACK_REACH = 3'd5;
  localparam logic [2:0] FMC_JOG_FWD    = 3'd6;
  localparam logic [2:0] FMC_JOG_BACK   = 3'd7;

  localparam logic [2:0] MMC_INIT  = 3'd0;
  localparam logic [2:0] MMC_IDLE  = 3'd1;
  localparam logic [2:0] MMC_FWD   = 3'd2;
  localparam logic [2:0] MMC_BACK  = 3'd3;
  localparam logic [2:0] MMC_BRAKE = 3'd4;

  typedef enum logic [7:0] {
    FM_INIT       = 8'b0000_0001,
    FM_IDLE       = 8'b0000_0010,
    FM_FWD_LEAVE  = 8'b0000_0100,
    FM_BACK_LEAVE = 8'b0000_1000,
    FM_FWD_REACH  = 8'b0001_0000,
    FM_BACK_REACH = 8'b0010_0000,
    FM_JOG_FWD    = 8'b0100_0000,
    FM_JOG_BACK   = 8'b1000_0000
  } fm_t;

  typedef enum logic [4:0] {
    MM_INIT  = 5'b00001,
    MM_IDLE  = 5'b00010,
    MM_FWD   = 5'b00100,
    MM_BACK  = 5'b01000,
    MM_BRAKE = 5'b10000
  } mm_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] enter_level;
    logic [LEVEL_W-1:0] leave_level;
    logic [TIMER_W-1:0] leave_tmo;
    logic [TIMER_W-1:0] reach_tmo;
    logic [BRAKE_W-1:0] brake_ticks;
    logic [PWM_W-1:0]   step_drive;
    logic [PWM_W-1:0]   jog_drive;
  } cfg_t;

  typedef struct packed {
    logic               feed_active;
    logic [1:0]         fwd_button_event;
    logic [1:0]         back_button_event;
    logic [LEVEL_W-1:0] opto_sample;
  } item_t;

  typedef struct packed {
    fm_t                       mode;
    logic [TIMER_W-1:0]        step_timer;
    logic                      fwd_pending;
    logic                      back_pending;
    logic                      fwd_jog;
    logic                      back_jog;
    logic                      prev_feed;
    logic                      indexed;
    logic signed [DRIVE_W-1:0] drive_request;
    mm_t                       motor_phase;
    logic [BRAKE_W-1:0]        brake_count;
    logic [PWM_W-1:0]          pole_a;
    logic [PWM_W-1:0]          pole_b;
  } state_t;

  typedef struct packed {
    logic [PWM_W-1:0] pole_a_pwm;
    logic [PWM_W-1:0] pole_b_pwm;
    logic [2:0]       feeder_mode;
    logic [2:0]       motor_mode;
    logic             index_seen;
  } result_t;

  function automatic logic [2:0] fm_code(input fm_t m);
    logic [2:0] c;
    case (m)
      FM_INIT:       c = FMC_INIT;
      FM_IDLE:       c = FMC_IDLE;
      FM_FWD_LEAVE:  c = FMC_FWD_LEAVE;
      FM_BACK_LEAVE: c = FMC_BACK_LEAVE;
      FM_FWD_REACH:  c = FMC_FWD_REACH;
      FM_BACK_REACH: c = FMC_BACK_REACH;
      FM_JOG_FWD:    c = FMC_JOG_FWD;
      FM_JOG_BACK:   c = FMC_JOG_BACK;
      default:       c = FMC_INIT;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] mm_code(input mm_t m);
    logic [2:0] c;
    case (m)
      MM_INIT:  c = MMC_INIT;
      MM_IDLE:  c = MMC_IDLE;
      MM_FWD:   c = MMC_FWD;
      MM_BACK:  c = MMC_BACK;
      MM_BRAKE: c = MMC_BRAKE;
      default:  c = MMC_INIT;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fimc_step.sv =====
// one tick of the controller: request latches, index hysteresis, feeder and motor machines
module fimc_step import fimc_pkg::*; (
  input  state_t  state,
  input  cfg_t    cfg,
  input  item_t   item,
  output state_t  state_nxt,
  output result_t result
);

  logic [PWM_W-1:0]          step_mag;
  logic [PWM_W-1:0]          jog_mag;
  logic signed [DRIVE_W-1:0] step_pos;
  logic signed [DRIVE_W-1:0] jog_pos;
  logic                      fp;
  logic                      bp;
  logic                      fj;
  logic                      bj;
  logic                      idx;
  logic                      fp_kept;
  logic                      bp_kept;
  fm_t                       mode;
  logic [TIMER_W-1:0]        timer;
  logic signed [DRIVE_W-1:0] drive;
  logic [DRIVE_W-1:0]        drive_abs;
  mm_t                       mphase;
  logic [BRAKE_W-1:0]        bcount;
  logic [PWM_W-1:0]          pa;
  logic [PWM_W-1:0]          pb;

  assign step_mag = (cfg.step_drive > PWM_FULL) ? PWM_FULL : cfg.step_drive;
  assign jog_mag  = (cfg.jog_drive > PWM_FULL) ? PWM_FULL : cfg.jog_drive;
  assign step_pos = $signed({1'b0, step_mag});
  assign jog_pos  = $signed({1'b0, jog_mag});

  // request latches and hysteresis
  always_comb begin
    fp = state.fwd_pending | (item.feed_active & ~state.prev_feed);
    bp = state.back_pending;
    fj = state.fwd_jog;
    bj = state.back_jog;
    case (item.fwd_button_event)
      BTN_SHORT: fp = 1'b1;
      BTN_HOLD:  fj = 1'b1;
      BTN_NONE:  fj = 1'b0;
      default:   fj = state.fwd_jog;
    endcase
    case (item.back_button_event)
      BTN_SHORT: bp = 1'b1;
      BTN_HOLD:  bj = 1'b1;
      BTN_NONE:  bj = 1'b0;
      default:   bj = state.back_jog;
    endcase
    idx = state.indexed ? (item.opto_sample > cfg.leave_level)
                        : (item.opto_sample > cfg.enter_level);
  end

  // feeder machine
  always_comb begin
    mode    = state.mode;
    timer   = state.step_timer;
    drive   = state.drive_request;
    fp_kept = fp;
    bp_kept = bp;
    case (state.mode)
      FM_INIT: begin
        mode  = FM_IDLE;
        timer = INIT_TIMER;
      end
      FM_IDLE: begin
        drive = '0;
        if (fp) begin
          mode  = FM_FWD_LEAVE;
          timer = cfg.leave_tmo;
        end
        if (bp) begin
          mode  = FM_BACK_LEAVE;
          timer = cfg.leave_tmo;
        end
        if (fj) mode = FM_JOG_FWD;
        if (bj) mode = FM_JOG_BACK;
        fp_kept = 1'b0;
        bp_kept = 1'b0;
      end
      FM_FWD_LEAVE, FM_BACK_LEAVE: begin
        drive = (state.mode == FM_FWD_LEAVE) ? step_pos : -step_pos;
        if (!idx) begin
          mode  = (state.mode == FM_FWD_LEAVE) ? FM_FWD_REACH : FM_BACK_REACH;
          timer = cfg.reach_tmo;
        end
        if (timer != '0) timer = timer - TIMER_W'(1);
        else mode = FM_IDLE;
      end
      FM_FWD_REACH, FM_BACK_REACH: begin
        drive = (state.mode == FM_FWD_REACH) ? step_pos : -step_pos;
        if (idx) mode = FM_IDLE;
        if (timer != '0) timer = timer - TIMER_W'(1);
        else mode = FM_IDLE;
      end
      FM_JOG_FWD: begin
        drive = jog_pos;
        if (!fj) begin
          mode  = FM_FWD_REACH;
          timer = cfg.reach_tmo;
        end
      end
      FM_JOG_BACK: begin
        drive = -jog_pos;
        if (!bj) begin
          mode  = FM_BACK_REACH;
          timer = cfg.reach_tmo;
        end
      end
      default: mode = FM_INIT;
    endcase
  end

  assign drive_abs = drive[DRIVE_W-1] ? -drive : drive;

  // motor machine, braking swaps the poles
  always_comb begin
    mphase = state.motor_phase;
    bcount = state.brake_count;
    pa     = state.pole_a;
    pb     = state.pole_b;
    case (state.motor_phase)
      MM_INIT: begin
        pa     = '0;
        pb     = '0;
        mphase = MM_IDLE;
      end
      MM_IDLE: begin
        pa = '0;
        pb = '0;
        if (drive > 0) mphase = MM_FWD;
        if (drive < 0) mphase = MM_BACK;
      end
      MM_FWD, MM_BACK: begin
        if (drive == 0) begin
          mphase = MM_BRAKE;
          bcount = cfg.brake_ticks;
          pa     = state.pole_b;
          pb     = state.pole_a;
        end else if (state.motor_phase == MM_FWD) begin
          pa = '0;
          pb = drive_abs[PWM_W-1:0];
        end else begin
          pa = drive_abs[PWM_W-1:0];
          pb = '0;
        end
      end
      MM_BRAKE: begin
        if (bcount != '0) bcount = bcount - BRAKE_W'(1);
        else mphase = MM_IDLE;
        if (drive != 0) mphase = MM_IDLE;
      end
      default: mphase = MM_INIT;
    endcase
  end

  always_comb begin
    state_nxt.mode          = mode;
    state_nxt.step_timer    = timer;
    state_nxt.fwd_pending   = fp_kept;
    state_nxt.back_pending  = bp_kept;
    state_nxt.fwd_jog       = fj;
    state_nxt.back_jog      = bj;
    state_nxt.prev_feed     = item.feed_active;
    state_nxt.indexed       = idx;
    state_nxt.drive_request = drive;
    state_nxt.motor_phase   = mphase;
    state_nxt.brake_count   = bcount;
    state_nxt.pole_a        = pa;
    state_nxt.pole_b        = pb;
    result.pole_a_pwm       = pa;
    result.pole_b_pwm       = pb;
    result.feeder_mode      = fm_code(mode);
    result.motor_mode       = mm_code(mphase);
    result.index_seen       = idx;
  end

endmodule

// ===== rtl/feeder_index_motor_controller.sv =====
// top level of the feeder index motor controller: channels, config registers, state
//
// one input transfer per system tick carries the feed level, the two button
// events and the optical sample; each one gives exactly one result transfer
// with the two pole duties, the feeder and motor modes and the index flag.
// an accepted item is held in the input register, then the tick logic
// (latches, hysteresis, feeder machine, motor machine) runs in a single pass
// into the state and the output register, which drives out_tvalid and
// out_tdata; one item is taken every cycle while the receiver keeps out_tready high.
// when the receiver stalls, the result holds in the output register and the
// input register still takes one more item; after that in_tready drops until
// the result is taken.
// synchronous reset (rst_n low) empties both registers, puts both machines
// in their init state and loads the config registers with their defaults.
// config writes (cfg_we, cfg_index, cfg_wdata) take effect at the next edge
// and are meant for times when no item is in flight; indexes past the last
// register are ignored.
module feeder_index_motor_controller import fimc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata from bit 0: feed_active[0], fwd_button_event[2:1],
  // back_button_event[4:3], opto_sample[16:5], zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata from bit 0: pole_a_pwm[11:0], pole_b_pwm[23:12],
  // feeder_mode[26:24], motor_mode[29:27], index_seen[30], zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam cfg_t CFG_RESET = '{
    enter_level: 12'd3200,
    leave_level: 12'd2800,
    leave_tmo:   16'd500,
    reach_tmo:   16'd1500,
    brake_ticks: 8'd8,
    step_drive:  12'd2048,
    jog_drive:   12'd2048
  };

  localparam state_t STATE_RESET = '{
    mode:          FM_INIT,
    step_timer:    '0,
    fwd_pending:   1'b0,
    back_pending:  1'b0,
    fwd_jog:       1'b0,
    back_jog:      1'b0,
    prev_feed:     1'b0,
    indexed:       1'b0,
    drive_request: '0,
    motor_phase:   MM_INIT,
    brake_count:   '0,
    pole_a:        '0,
    pole_b:        '0
  };

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  logic    in_valid_r;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_xfer;

  // the tick runs when an item waits and the output register is free or draining
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign in_xfer   = in_tvalid & in_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTER_LEVEL: cfg_r.enter_level <= cfg_wdata[LEVEL_W-1:0];
        CFG_LEAVE_LEVEL: cfg_r.leave_level <= cfg_wdata[LEVEL_W-1:0];
        CFG_LEAVE_TMO:   cfg_r.leave_tmo   <= cfg_wdata[TIMER_W-1:0];
        CFG_REACH_TMO:   cfg_r.reach_tmo   <= cfg_wdata[TIMER_W-1:0];
        CFG_BRAKE_TICKS: cfg_r.brake_ticks <= cfg_wdata[BRAKE_W-1:0];
        CFG_STEP_DRIVE:  cfg_r.step_drive  <= cfg_wdata[PWM_W-1:0];
        CFG_JOG_DRIVE:   cfg_r.jog_drive   <= cfg_wdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.feed_active       <= in_tdata[0];
      item_r.fwd_button_event  <= in_tdata[2:1];
      item_r.back_button_event <= in_tdata[4:3];
      item_r.opto_sample       <= in_tdata[16:5];
    end
  end

  fimc_step u_step (
    .state     (state_r),
    .cfg       (cfg_r),
    .item      (item_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // controller state moves only when a tick runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.index_seen, res_r.motor_mode, res_r.feeder_mode,
                       res_r.pole_b_pwm, res_r.pole_a_pwm};

  // the poles are never driven against each other
  a_poles_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.pole_a_pwm == '0 || res_r.pole_b_pwm == '0))
    else $error("both pole duties nonzero");

  // duty never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.pole_a_pwm <= PWM_FULL && res_r.pole_b_pwm <= PWM_FULL))
    else $error("pole duty above full scale");

  // a tick that runs always leaves a result behind
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("tick ran without a result");

endmodule
